// File: rtl/tfp_pkg.sv
// Shared widths, constants, register indexes and types of the PD tape-follower steering block.
package tfp_pkg;

    localparam int ERR_W   = 7;
    localparam int MAG_W   = 6;
    localparam int SPEED_W = 16;
    localparam int TIME_W  = 32;
    localparam int KNOB_W  = 10;

    // Serial divider: dividend width and divisor width.
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 32;

    // Serial multiplier: multiplicand width and multiplier width.
    localparam int MUL_AW = 38;
    localparam int MUL_BW = 15;

    // 2560000 = 4096 * 625: the power of two is a shift, the rest a serial division.
    localparam int CORR_SHIFT = 12;
    localparam int CORR_DIV   = 625;
    localparam int PROP_SHIFT = 14;

    localparam logic [1:0] CFG_ONE_SIDE = 2'd0;
    localparam logic [1:0] CFG_BOTH_OFF = 2'd1;
    localparam logic [1:0] CFG_BASE     = 2'd2;

    localparam logic [MAG_W-1:0]   ONE_SIDE_RESET = 6'd2;
    localparam logic [MAG_W-1:0]   BOTH_OFF_RESET = 6'd10;
    localparam logic [SPEED_W-1:0] BASE_RESET     = 16'd26214;

    typedef struct packed {
        logic busy;
        logic done;
    } tfp_unit_stat_t;

endpackage

// File: rtl/tfp_serial_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module tfp_serial_div
    import tfp_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DW-1:0]  divisor,
    output logic [NW-1:0]  quotient,
    output tfp_unit_stat_t stat
);

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/tfp_serial_mul.sv
// Shift-add unsigned multiplier that consumes one multiplier bit per cycle.
module tfp_serial_mul
    import tfp_pkg::*;
#(
    parameter int AW = MUL_AW,
    parameter int BW = MUL_BW
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    mcand,
    input  logic [BW-1:0]    mplier,
    output logic [AW+BW-1:0] product,
    output tfp_unit_stat_t   stat
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [AW:0]      upper;

    assign upper = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = {{AW{1'b0}}, mplier};
            a_next    = mcand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {upper, acc_reg[BW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/tape_follow_pd_steering.sv
// Top level of the PD tape-follower steering block: error tracking, sequencer and output register.
// From input accept to result valid: a serial division of 36 quotient bits, three serial
// multiplications of 15 bits, a second division of 36 quotient bits, and the output load.
// A new item is accepted only in idle, so the shared serial divider and multiplier serve one
// item at a time; a finished result waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous): registers return to 2, 10 and 26214, history clears to zero.
module tape_follow_pd_steering
    import tfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_on_tape[0], right_on_tape[1], now_ms[33:2], prop_knob[43:34],
    // deriv_knob[53:44], overall_knob[63:54], run_enable[64], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tape_error[6:0], left_speed[22:7], right_speed[38:23], motors_running[39]
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVD = 3'd1;
    localparam logic [2:0] ST_MULP = 3'd2;
    localparam logic [2:0] ST_MULD = 3'd3;
    localparam logic [2:0] ST_MULG = 3'd4;
    localparam logic [2:0] ST_DIVC = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam int SUM_W  = 40;
    localparam int DQ_W   = 24;
    localparam int CORR_W = 28;
    localparam int WIDE_W = 29;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
        logic [SPEED_W-1:0] r;
        if (v > WIDE_W'(32767)) begin
            r = 16'h7FFF;
        end else if (v < -WIDE_W'(32767)) begin
            r = 16'h8001;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    logic [2:0] state_reg, state_next;
    logic       start_reg, start_next;

    logic [MAG_W-1:0]   one_side_reg;
    logic [MAG_W-1:0]   both_off_reg;
    logic [SPEED_W-1:0] base_reg;

    logic signed [ERR_W-1:0] prev_err_reg;
    logic [TIME_W-1:0]       prior_time_reg;
    logic [TIME_W-1:0]       latest_time_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W:0]    diff_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic [KNOB_W-1:0]        kp_reg, kd_reg, gain_reg;
    logic                     run_reg;
    logic signed [DQ_W-1:0]   dq_reg, dq_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [CORR_W-1:0] corr_reg, corr_next;

    logic                     m_valid_reg, m_valid_next;
    logic [ERR_W-1:0]         out_err_reg;
    logic [SPEED_W-1:0]       out_left_reg, out_right_reg;
    logic                     out_run_reg;

    logic                     in_left, in_right, in_run;
    logic [TIME_W-1:0]        in_now;
    logic [KNOB_W-1:0]        in_kp, in_kd, in_gain;
    logic                     accept;
    logic signed [ERR_W-1:0]  err_cur;
    logic signed [ERR_W:0]    diff_cur;
    logic                     err_change;
    logic [TIME_W-1:0]        prior_sel;
    logic [TIME_W-1:0]        dt_raw;

    logic [ERR_W:0]           diff_neg;
    logic [ERR_W-1:0]         err_neg;
    logic [DQ_W-1:0]          dq_neg;
    logic [SUM_W-1:0]         sum_neg;
    logic [KNOB_W+4:0]        kd_scaled;
    logic [SUM_W-1:0]         p1_ext, p2_ext;
    logic [CORR_W-1:0]        q_corr;
    logic [DQ_W-1:0]          q_dq;
    logic signed [WIDE_W-1:0] base_wide, corr_wide, left_wide, right_wide;
    logic                     out_load;

    logic [DIV_NW-1:0]        div_n, div_q;
    logic [DIV_DW-1:0]        div_d;
    logic [MUL_AW-1:0]        mul_a;
    logic [MUL_BW-1:0]        mul_b;
    logic [MUL_AW+MUL_BW-1:0] mul_p;
    tfp_unit_stat_t           div_stat, mul_stat;

    assign in_left  = s_tdata[0];
    assign in_right = s_tdata[1];
    assign in_now   = s_tdata[33:2];
    assign in_kp    = s_tdata[43:34];
    assign in_kd    = s_tdata[53:44];
    assign in_gain  = s_tdata[63:54];
    assign in_run   = s_tdata[64];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (in_left && in_right) begin
            err_cur = '0;
        end else if (in_right) begin
            err_cur = -$signed({1'b0, one_side_reg});
        end else if (in_left) begin
            err_cur = $signed({1'b0, one_side_reg});
        end else if (prev_err_reg < 0) begin
            err_cur = -$signed({1'b0, both_off_reg});
        end else begin
            err_cur = $signed({1'b0, both_off_reg});
        end
    end

    assign diff_cur   = $signed({err_cur[ERR_W-1], err_cur})
                      - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
    assign err_change = (err_cur != prev_err_reg);
    assign prior_sel  = err_change ? latest_time_reg : prior_time_reg;
    assign dt_raw     = in_now - prior_sel;

    assign diff_neg  = -diff_reg;
    assign err_neg   = -err_reg;
    assign dq_neg    = -dq_reg;
    assign sum_neg   = -sum_reg;
    assign kd_scaled = {1'b0, kd_reg, 4'b0} + {2'b0, kd_reg, 3'b0} + {5'b0, kd_reg};

    always_comb begin
        div_n = '0;
        div_d = dt_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DIVD: begin
                div_n = {13'b0, (diff_reg[ERR_W] ? diff_neg[ERR_W-1:0] : diff_reg[ERR_W-1:0]),
                         16'b0};
                div_d = dt_reg;
            end
            ST_MULP: begin
                mul_a = {{(MUL_AW-ERR_W){1'b0}}, (err_reg[ERR_W-1] ? err_neg : err_reg)};
                mul_b = {{(MUL_BW-KNOB_W){1'b0}}, kp_reg};
            end
            ST_MULD: begin
                mul_a = {{(MUL_AW-DQ_W){1'b0}}, (dq_reg[DQ_W-1] ? dq_neg : dq_reg)};
                mul_b = kd_scaled;
            end
            ST_MULG: begin
                mul_a = sum_reg[SUM_W-1] ? sum_neg[MUL_AW-1:0] : sum_reg[MUL_AW-1:0];
                mul_b = {{(MUL_BW-KNOB_W){1'b0}}, gain_reg};
            end
            ST_DIVC: begin
                div_n = mul_p[DIV_NW+CORR_SHIFT-1:CORR_SHIFT];
                div_d = DIV_DW'(CORR_DIV);
            end
            default: begin
                div_n = '0;
            end
        endcase
    end

    tfp_serial_div #(
        .NW(DIV_NW),
        .DW(DIV_DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg && (state_reg == ST_DIVD || state_reg == ST_DIVC)),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .stat     (div_stat)
    );

    tfp_serial_mul #(
        .AW(MUL_AW),
        .BW(MUL_BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg && (state_reg == ST_MULP || state_reg == ST_MULD ||
                                state_reg == ST_MULG)),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    assign q_dq   = {1'b0, div_q[DQ_W-2:0]};
    assign q_corr = {1'b0, div_q[CORR_W-2:0]};
    assign p1_ext = {{(SUM_W-16-PROP_SHIFT){1'b0}}, mul_p[15:0], {PROP_SHIFT{1'b0}}};
    assign p2_ext = {{(SUM_W-MUL_AW){1'b0}}, mul_p[MUL_AW-1:0]};

    assign base_wide  = {{(WIDE_W-SPEED_W){base_reg[SPEED_W-1]}}, base_reg};
    assign corr_wide  = {corr_reg[CORR_W-1], corr_reg};
    assign left_wide  = base_wide - corr_wide;
    assign right_wide = base_wide + corr_wide;
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        start_next   = 1'b0;
        dq_next      = dq_reg;
        sum_next     = sum_reg;
        corr_next    = corr_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIVD;
                    start_next = 1'b1;
                end
            end
            ST_DIVD: begin
                if (div_stat.done) begin
                    dq_next    = diff_reg[ERR_W] ? -$signed(q_dq) : $signed(q_dq);
                    state_next = ST_MULP;
                    start_next = 1'b1;
                end
            end
            ST_MULP: begin
                if (mul_stat.done) begin
                    sum_next   = err_reg[ERR_W-1] ? -$signed(p1_ext) : $signed(p1_ext);
                    state_next = ST_MULD;
                    start_next = 1'b1;
                end
            end
            ST_MULD: begin
                if (mul_stat.done) begin
                    sum_next   = sum_reg + (dq_reg[DQ_W-1] ? -$signed(p2_ext) : $signed(p2_ext));
                    state_next = ST_MULG;
                    start_next = 1'b1;
                end
            end
            ST_MULG: begin
                if (mul_stat.done) begin
                    state_next = ST_DIVC;
                    start_next = 1'b1;
                end
            end
            ST_DIVC: begin
                if (div_stat.done) begin
                    corr_next  = sum_reg[SUM_W-1] ? -$signed(q_corr) : $signed(q_corr);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            start_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            one_side_reg    <= ONE_SIDE_RESET;
            both_off_reg    <= BOTH_OFF_RESET;
            base_reg        <= BASE_RESET;
            prev_err_reg    <= '0;
            prior_time_reg  <= '0;
            latest_time_reg <= '0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ONE_SIDE: one_side_reg <= cfg_data[MAG_W-1:0];
                    CFG_BOTH_OFF: both_off_reg <= cfg_data[MAG_W-1:0];
                    CFG_BASE:     base_reg     <= cfg_data;
                    default:      base_reg     <= base_reg;
                endcase
            end
            if (accept) begin
                prev_err_reg <= err_cur;
                if (err_change) begin
                    prior_time_reg  <= latest_time_reg;
                    latest_time_reg <= in_now;
                end
            end
        end
        if (accept) begin
            err_reg  <= err_cur;
            diff_reg <= diff_cur;
            dt_reg   <= (dt_raw == '0) ? TIME_W'(1) : dt_raw;
            kp_reg   <= in_kp;
            kd_reg   <= in_kd;
            gain_reg <= in_gain;
            run_reg  <= in_run;
        end
        dq_reg   <= dq_next;
        sum_reg  <= sum_next;
        corr_reg <= corr_next;
        if (out_load) begin
            out_err_reg   <= err_reg;
            out_left_reg  <= run_reg ? sat_speed(left_wide) : '0;
            out_right_reg <= run_reg ? sat_speed(right_wide) : '0;
            out_run_reg   <= run_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_run_reg, out_right_reg, out_left_reg, out_err_reg};

    // An accepted item keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A stopped result always carries zero speeds.
    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_run_reg) |-> (out_left_reg == '0 && out_right_reg == '0))
        else $error("nonzero speed with motors stopped");

    // Saturation never yields the most negative code.
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_left_reg != 16'h8000 && out_right_reg != 16'h8000))
        else $error("speed outside saturation range");

    // The divider and multiplier are never active together.
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy at once");

endmodule

// File: tb/steering_checker.sv
// Checker for the PD tape-follower steering block: predicts each wheel-speed result and compares.
module steering_checker
    import tfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [71:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int unsigned       pending,
    output int unsigned       mismatches,
    output int unsigned       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PROP_SCALE = 16384;
    localparam longint DERIV_SCALE = 25;
    localparam longint DERIV_ONE = 65536;
    localparam longint CORR_SCALE = 2560000;
    localparam longint SPEED_MAX = 32767;

    typedef struct packed {
        logic signed [ERR_W-1:0]   tape_error;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      motors_running;
    } wheel_result_t;

    logic [MAG_W-1:0]          one_side_mm;
    logic [MAG_W-1:0]          both_off_mm;
    logic signed [SPEED_W-1:0] base_q15;
    logic signed [ERR_W-1:0]   last_error;
    logic [TIME_W-1:0]         prior_change_ms;
    logic [TIME_W-1:0]         latest_change_ms;
    wheel_result_t             expected_speeds[$];

    initial begin
        pending = 0;
        mismatches = 0;
        checked = 0;
    end

    function automatic longint clamp_speed(input longint v);
        if (v > SPEED_MAX) return SPEED_MAX;
        if (v < -SPEED_MAX) return -SPEED_MAX;
        return v;
    endfunction

    function automatic void predict_wheel_speeds(input logic [71:0] d);
        logic          left_on;
        logic          right_on;
        logic          run;
        logic [31:0]   now_ms;
        logic [31:0]   elapsed;
        longint        kp;
        longint        kd;
        longint        gain;
        longint        err_now;
        longint        slope;
        longint        corr;
        longint        lsp;
        longint        rsp;
        wheel_result_t r;
        left_on = d[0];
        right_on = d[1];
        now_ms = d[33:2];
        kp = longint'(d[43:34]);
        kd = longint'(d[53:44]);
        gain = longint'(d[63:54]);
        run = d[64];
        if (left_on && right_on) begin
            err_now = 0;
        end else if (right_on) begin
            err_now = -longint'(one_side_mm);
        end else if (left_on) begin
            err_now = longint'(one_side_mm);
        end else begin
            err_now = (last_error < 0) ? -longint'(both_off_mm) : longint'(both_off_mm);
        end
        if (err_now != longint'(last_error)) begin
            prior_change_ms = latest_change_ms;
            latest_change_ms = now_ms;
        end
        elapsed = now_ms - prior_change_ms;
        if (elapsed == 0) begin
            elapsed = 1;
        end
        slope = ((err_now - longint'(last_error)) * DERIV_ONE) / longint'(elapsed);
        corr = (gain * (kp * err_now * PROP_SCALE + kd * slope * DERIV_SCALE)) / CORR_SCALE;
        if (run) begin
            lsp = clamp_speed(longint'(base_q15) - corr);
            rsp = clamp_speed(longint'(base_q15) + corr);
        end else begin
            lsp = 0;
            rsp = 0;
        end
        last_error = err_now[ERR_W-1:0];
        r.tape_error = err_now[ERR_W-1:0];
        r.left_speed = lsp[SPEED_W-1:0];
        r.right_speed = rsp[SPEED_W-1:0];
        r.motors_running = run;
        expected_speeds.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int want, input int got,
                                        input logic known);
        if (!known || want != got) begin
            $display("%0t ns: %s expected %0d got %0d%s", $time, name, want, got,
                     known ? "" : " (unknown bits)");
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        wheel_result_t want;
        if (!aresetn) begin
            one_side_mm = ONE_SIDE_RESET;
            both_off_mm = BOTH_OFF_RESET;
            base_q15 = BASE_RESET;
            last_error = '0;
            prior_change_ms = '0;
            latest_change_ms = '0;
            expected_speeds.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_speeds.size() == 0) begin
                    $display("%0t ns: result %h arrived with no item outstanding", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_speeds.pop_front();
                    checked++;
                    check_field("tape_error", int'(want.tape_error), int'($signed(m_tdata[6:0])),
                                !$isunknown(m_tdata[6:0]));
                    check_field("left_speed", int'(want.left_speed),
                                int'($signed(m_tdata[22:7])), !$isunknown(m_tdata[22:7]));
                    check_field("right_speed", int'(want.right_speed),
                                int'($signed(m_tdata[38:23])), !$isunknown(m_tdata[38:23]));
                    check_field("motors_running", int'(want.motors_running), int'(m_tdata[39]),
                                !$isunknown(m_tdata[39]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ONE_SIDE: one_side_mm = cfg_data[MAG_W-1:0];
                    CFG_BOTH_OFF: both_off_mm = cfg_data[MAG_W-1:0];
                    CFG_BASE:     base_q15 = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_wheel_speeds(s_tdata);
            end
        end
        pending <= expected_speeds.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the steering testbench: clock, reset, item and register stimulus, and the verdict.
module tb_top;
    import tfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 6;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 130;
    localparam int RUN_LIMIT_NS = 4_000_000;
    localparam logic [9:0] KNOB_MAX = 10'd1023;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ONE_SIDE;
    logic [15:0] cfg_data = '0;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned checked;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_kick = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned items_sent = 0;
    int unsigned settings_run = 0;

    logic [31:0] clock_ms;
    logic        left_now;
    logic        right_now;
    logic [9:0]  kp_now;
    logic [9:0]  kd_now;
    logic [9:0]  gain_now;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    tape_follow_pd_steering u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    steering_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .checked    (checked)
    );

    // The receiver stalls at random, or holds off entirely for a long stretch on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer_item(input logic l, input logic r, input logic [31:0] t,
                              input logic [9:0] kp, input logic [9:0] kd,
                              input logic [9:0] gain, input logic run);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, run, gain, kd, kp, t, r, l};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [9:0] pick_knob;
        if ($urandom_range(9) == 0) begin
            return $urandom_range(1) ? KNOB_MAX : 10'd0;
        end
        return 10'($urandom_range(1023));
    endfunction

    task automatic random_item;
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        if (pick < 8) begin
            offer_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                       10'($urandom_range(1023)), 10'($urandom_range(1023)),
                       10'($urandom_range(1023)), 1'($urandom_range(1)));
        end else begin
            if ($urandom_range(3) == 0) begin
                left_now = 1'($urandom_range(1));
                right_now = 1'($urandom_range(1));
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                step = 0;
            end else if (pick < 75) begin
                step = $urandom_range(40, 1);
            end else if (pick < 92) begin
                step = $urandom_range(3000, 41);
            end else begin
                step = $urandom();
            end
            clock_ms = clock_ms + step;
            if ($urandom_range(15) == 0) begin
                kp_now = pick_knob();
                kd_now = pick_knob();
                gain_now = pick_knob();
            end
            offer_item(left_now, right_now, clock_ms, kp_now, kd_now, gain_now,
                       $urandom_range(19) != 0);
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("run did not finish by %0t ns", $time);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct <= 11;
        recv_idle_pct <= 50;
        @(posedge aclk);

        // Reset register values: both on, one side, both off following the last sign,
        // repeated timestamps, run low, and time wrapping past the top of the counter.
        offer_item(1'b1, 1'b1, 32'd0, 10'd0, 10'd0, 10'd0, 1'b1);
        offer_item(1'b0, 1'b1, 32'd5, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b0, 1'b0, 32'd5, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b0, 1'b0, 32'd5, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b1, 1'b0, 32'd9, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b0);
        offer_item(1'b0, 1'b0, 32'd20, 10'd512, 10'd1, 10'd1023, 1'b1);
        offer_item(1'b1, 1'b1, 32'd20, 10'd1, 10'd512, 10'd1023, 1'b1);
        offer_item(1'b0, 1'b0, 32'd21, KNOB_MAX, 10'd0, KNOB_MAX, 1'b1);
        offer_item(1'b1, 1'b1, 32'd21, 10'd0, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b1, 1'b0, 32'hFFFF_FFF0, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b0, 1'b1, 32'd5, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b0, 1'b1, 32'hFFFF_FFFF, 10'd0, 10'd0, 10'd0, 1'b0);
        offer_item(1'b0, 1'b0, 32'hFFFF_FFFF, KNOB_MAX, KNOB_MAX, 10'd0, 1'b1);
        offer_item(1'b1, 1'b1, 32'hFFFF_FFFF, KNOB_MAX, KNOB_MAX, 10'd1, 1'b1);
        offer_item(1'b1, 1'b0, 32'h5555_5555, 10'h155, 10'h2AA, 10'h155, 1'b1);
        offer_item(1'b0, 1'b1, 32'hAAAA_AAAA, 10'h2AA, 10'h155, 10'h2AA, 1'b1);
        offer_item(1'b1, 1'b0, 32'hAAAA_AAAB, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b1);
        offer_item(1'b0, 1'b0, 32'hAAAA_AAAB, KNOB_MAX, KNOB_MAX, KNOB_MAX, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct <= 11;
                recv_idle_pct <= 50;
            end else if (ph < 4) begin
                send_idle_pct <= 50;
                recv_idle_pct <= 11;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case (ph)
                0: begin
                    write_reg(CFG_ONE_SIDE, 16'd63);
                    write_reg(CFG_BOTH_OFF, 16'd63);
                    write_reg(CFG_BASE, 16'h8000);
                    write_reg(CFG_UNUSED, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_ONE_SIDE, 16'hFFC0);
                    write_reg(CFG_BOTH_OFF, 16'd0);
                    write_reg(CFG_BASE, 16'h7FFF);
                end
                4: begin
                    write_reg(CFG_ONE_SIDE, 16'd1);
                    write_reg(CFG_BOTH_OFF, 16'd63);
                    write_reg(CFG_BASE, 16'd0);
                end
                default: begin
                    write_reg(CFG_ONE_SIDE, 16'($urandom()));
                    write_reg(CFG_BOTH_OFF, 16'($urandom()));
                    write_reg(CFG_BASE, 16'($urandom()));
                end
            endcase
            cfg_valid <= 1'b0;
            settings_run++;
            if (ph == 4) begin
                hold_kick <= hold_kick + 1;
            end
            clock_ms = (ph == 3) ? 32'hFFFF_F000 : $urandom();
            left_now = 1'($urandom_range(1));
            right_now = 1'($urandom_range(1));
            kp_now = pick_knob();
            kd_now = pick_knob();
            gain_now = pick_knob();
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                random_item();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("summary: %0d items sent, %0d results checked over %0d register settings,",
                 items_sent, checked, settings_run + 1);
        $display("summary: idle mixes 11/50, 50/11 and none, one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (pending != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
